@@ rtl/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// sha_pkg
// Shared constants and round functions for the byte-serial SHA-256 engine.
// ----------------------------------------------------------------------------
package sha_pkg;

   localparam int unsigned QueueDepth = 4;

   // command from front to back
   typedef enum logic [1:0] {
      CMD_BLOCK = 2'd0,   // compress the block that was handed over
      CMD_FINAL = 2'd1,   // compress final block, then emit digest
      CMD_PAD   = 2'd2    // compress padding overflow block, more follows
   } cmd_type;

   typedef struct packed {
      cmd_type      cmd;
      logic [511:0] block;
   } job_type;

   typedef logic [7:0][31:0] hash_type;

   localparam hash_type InitHash = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k;
      unique case (idx)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
         6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
         6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
         6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
      return (v >> n) | (v << (32 - n));
   endfunction

endpackage

@@ rtl/sha_front.sv @@
// ----------------------------------------------------------------------------
// sha_front
// Gathers message bytes into 64-byte blocks, counts length and builds the
// padding blocks; hands each block to the job queue.
// ----------------------------------------------------------------------------
module sha_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [7:0]        req_data_byte,
   input  logic              req_has_byte,
   input  logic              req_end_of_message,
   output logic              job_valid,
   output sha_pkg::job_type  job_data,
   input  logic              job_ready
);

   typedef enum logic [1:0] {
      ST_FILL,
      ST_PAD1,     // emit first padding block (may be final)
      ST_PAD2      // emit length-only block
   } state_type;

   state_type    state_ff, state_in;
   logic [60:0]  count_ff, count_in;
   logic [511:0] buf_ff, buf_in;
   logic         valid_ff, valid_in;
   sha_pkg::job_type job_ff, job_in;

   logic [5:0]   fill;
   logic [511:0] pad_blk, len_blk;
   logic [63:0]  bits;
   logic         acc;

   assign fill     = count_ff[5:0];
   assign bits     = {count_ff, 3'b000};
   assign job_valid = valid_ff;
   assign job_data  = job_ff;
   assign req_full = (state_ff != ST_FILL) || (valid_ff && !job_ready);
   assign acc      = req_push && !req_full;

   // padding block: 0x80 after fill, zeros, length if room
   always_comb begin
      pad_blk = '0;
      for (int i = 0; i < 64; i++) begin
         if (6'(i) < fill) pad_blk[511-8*i -: 8] = buf_ff[511-8*i -: 8];
         else if (6'(i) == fill) pad_blk[511-8*i -: 8] = 8'h80;
      end
      len_blk = '0;
      len_blk[63:0] = bits;
      if (fill < 6'd56) pad_blk[63:0] = bits;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      buf_in   = buf_ff;
      valid_in = valid_ff && !job_ready;
      job_in   = job_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (acc) begin
               if (req_has_byte) begin
                  buf_in[511-8*fill -: 8] = req_data_byte;
                  count_in = count_ff + 61'd1;
                  if (fill == 6'd63) begin
                     valid_in  = 1'b1;
                     job_in.cmd   = sha_pkg::CMD_BLOCK;
                     job_in.block = buf_in;
                  end
               end
               if (req_end_of_message) state_in = ST_PAD1;
            end
         end
         ST_PAD1: begin
            if (!valid_ff || job_ready) begin
               valid_in     = 1'b1;
               job_in.block = pad_blk;
               if (fill < 6'd56) begin
                  job_in.cmd = sha_pkg::CMD_FINAL;
                  count_in   = '0;
                  state_in   = ST_FILL;
               end else begin
                  job_in.cmd = sha_pkg::CMD_PAD;
                  state_in   = ST_PAD2;
               end
            end
         end
         ST_PAD2: begin
            if (!valid_ff || job_ready) begin
               valid_in     = 1'b1;
               job_in.block = len_blk;
               job_in.cmd   = sha_pkg::CMD_FINAL;
               count_in     = '0;
               state_in     = ST_FILL;
            end
         end
         default: state_in = ST_FILL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      buf_ff <= buf_in;
      job_ff <= job_in;
   end

endmodule

@@ rtl/sha_queue.sv @@
// ----------------------------------------------------------------------------
// sha_queue
// Short job queue between the byte front and the compression back.
// ----------------------------------------------------------------------------
module sha_queue #(
   parameter int unsigned Depth = sha_pkg::QueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  sha_pkg::job_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output sha_pkg::job_type  out_data
);

   localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

   sha_pkg::job_type mem [Depth];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          wr, rd;

   assign in_ready  = cnt_ff != (AW+1)'(Depth);
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem[rd_ff];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;

   // pointer update with wrap at depth
   always_comb begin
      wr_in  = wr ? ((wr_ff == AW'(Depth-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = rd ? ((rd_ff == AW'(Depth-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(wr) - (AW+1)'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (wr) mem[wr_ff] <= in_data;
   end

endmodule

@@ rtl/sha_back.sv @@
// ----------------------------------------------------------------------------
// sha_back
// Runs 64 compression rounds per block, one round a cycle, and serves the
// digest as eight words through a result register.
// ----------------------------------------------------------------------------
module sha_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  sha_pkg::job_type  job_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [31:0]       rsp_digest_word,
   output logic [2:0]        rsp_word_index,
   output logic              rsp_last_word
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   sha_pkg::hash_type  hash_ff, hash_in;
   logic [7:0][31:0]   var_ff, var_in;
   logic [15:0][31:0]  win_ff, win_in;
   logic [5:0]         rnd_ff, rnd_in;
   logic               fin_ff, fin_in;
   logic [2:0]         idx_ff, idx_in;

   logic [31:0] w, s0, s1, x0, x1, ch, maj, t1, t2;

   assign job_ready       = state_ff == ST_IDLE;
   assign rsp_empty       = state_ff != ST_EMIT;
   assign rsp_digest_word = hash_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = idx_ff == 3'd7;

   // one round; window shifts so slot 0 is always the current word
   always_comb begin
      x0 = sha_pkg::rotr(win_ff[1], 7) ^ sha_pkg::rotr(win_ff[1], 18) ^ (win_ff[1] >> 3);
      x1 = sha_pkg::rotr(win_ff[14], 17) ^ sha_pkg::rotr(win_ff[14], 19)
         ^ (win_ff[14] >> 10);
      w   = win_ff[0];
      s1  = sha_pkg::rotr(var_ff[4], 6) ^ sha_pkg::rotr(var_ff[4], 11)
          ^ sha_pkg::rotr(var_ff[4], 25);
      ch  = (var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]);
      t1  = var_ff[7] + s1 + ch + sha_pkg::round_k(rnd_ff) + w;
      s0  = sha_pkg::rotr(var_ff[0], 2) ^ sha_pkg::rotr(var_ff[0], 13)
          ^ sha_pkg::rotr(var_ff[0], 22);
      maj = (var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]);
      t2  = s0 + maj;
   end

   always_comb begin
      state_in = state_ff;
      hash_in  = hash_ff;
      var_in   = var_ff;
      win_in   = win_ff;
      rnd_in   = rnd_ff;
      fin_in   = fin_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               for (int i = 0; i < 16; i++) win_in[i] = job_data.block[511-32*i -: 32];
               var_in   = hash_ff;
               rnd_in   = '0;
               fin_in   = job_data.cmd == sha_pkg::CMD_FINAL;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            var_in = {var_ff[6], var_ff[5], var_ff[4], var_ff[3] + t1,
                      var_ff[2], var_ff[1], var_ff[0], t1 + t2};
            for (int i = 0; i < 15; i++) win_in[i] = win_ff[i+1];
            win_in[15] = win_ff[0] + x0 + win_ff[9] + x1;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) state_in = ST_ADD;
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) hash_in[i] = hash_ff[i] + var_ff[i];
            idx_in   = '0;
            state_in = fin_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (rsp_pop) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  hash_in  = sha_pkg::InitHash;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hash_ff  <= sha_pkg::InitHash;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         hash_ff  <= hash_in;
         idx_ff   <= idx_in;
      end
      var_ff <= var_in;
      win_ff <= win_in;
      rnd_ff <= rnd_in;
      fin_ff <= fin_in;
   end

endmodule

@@ rtl/sha256_hash_engine.sv @@
// ----------------------------------------------------------------------------
// sha256_hash_engine
// Byte-serial SHA-256: bytes in, eight digest words out per message.
//
//  channel | ports                                  | handshake
//  req     | data_byte, has_byte, end_of_message    | push / full
//  rsp     | digest_word, word_index, last_word     | pop / empty
//
// Bytes are taken one a cycle; a full block goes to a job queue and the back
// part compresses it by a load, 64 rounds and an add, one round a cycle.
// Front stalls only when the queue is full or while emitting padding blocks
// (one or two). Digest words appear after the final block, one per pop.
// Synchronous active-high reset restores the initial hash and empty queue.
// ----------------------------------------------------------------------------
module sha256_hash_engine #(
   parameter int unsigned QueueDepth = sha_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   sha_pkg::job_type f_data, b_data;
   logic f_valid, f_ready, b_valid, b_ready;

   sha_front u_front (
      .clock, .reset, .req_push, .req_full, .req_data_byte, .req_has_byte,
      .req_end_of_message,
      .job_valid(f_valid), .job_data(f_data), .job_ready(f_ready)
   );

   sha_queue #(.Depth(QueueDepth)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
   );

   sha_back u_back (
      .clock, .reset,
      .job_valid(b_valid), .job_ready(b_ready), .job_data(b_data),
      .rsp_empty, .rsp_pop, .rsp_digest_word, .rsp_word_index, .rsp_last_word
   );

endmodule
